[sv/masked_random_stamp_generator_unit_defines.svh]
// Assertion macros used by the stamp generator controller.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef MASKED_RANDOM_STAMP_GENERATOR_UNIT_DEFINES_SVH
`define MASKED_RANDOM_STAMP_GENERATOR_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MRSG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define MRSG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/mrsg_pkg.sv]
// Types and constants of the masked random stamp generator.
// No dependencies; used by the controller and the top level.
package mrsg_pkg;

  localparam int unsigned TW_N   = 312;
  localparam int unsigned TW_M   = 156;
  localparam int unsigned ADDR_W = 9;
  localparam int unsigned WORD_W = 64;

  localparam logic [63:0] TW_MATRIX = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] TW_UPPER  = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] TW_LOWER  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [31:0] INIT_MUL_LO = 32'h4C95_7F2D;
  localparam logic [31:0] INIT_MUL_HI = 32'h5851_F42D;

  localparam logic [7:0] REG_MIN_FIRST  = 8'd0;
  localparam logic [7:0] REG_MIN_SECOND = 8'd1;
  localparam logic [7:0] REG_MAX_FIRST  = 8'd2;
  localparam logic [7:0] REG_MAX_SECOND = 8'd3;

  localparam logic OP_SEED = 1'b0;
  localparam logic OP_NEXT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SM0,
    ST_SM1,
    ST_SM2,
    ST_SM3,
    ST_RA,
    ST_RB,
    ST_RC,
    ST_WR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] first_raw;
    logic [7:0] second_raw;
    logic       last;
  } res_t;

endpackage

[sv/masked_random_stamp_generator_unit.sv]
// Top level of the masked random stamp generator: configuration registers,
// output register, state RAM. Uses mrsg_pkg, mrsg_ctrl and mrsg_ram.
//
// A seed word (tuser 0) keeps the block busy while it loads: the first
// state word is written on acceptance, then each of the other 311 words
// passes through states SM0 to SM3 and the shared 32x32 multiplier. For
// a next word (tuser 1), each of the two draws makes three reads through
// the single read port of the state RAM and one write back, and the
// EMIT state then hands the stamp entry over to the output register.
// The output register lets the next word be accepted while an entry
// waits to be taken. The state RAM has no clearing pass; a next word
// before any seed returns undefined bytes.
module masked_random_stamp_generator_unit #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] seed
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] first_value, [15:8] second_value
  output logic        out_tlast,  // last_entry
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import mrsg_pkg::*;

  logic [7:0] min_first_r, min_second_r, max_first_r, max_second_r;

  mem_req_t    mem;
  logic [63:0] mem_rdata;
  logic        res_valid;
  logic        res_ready;
  res_t        res;

  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic        out_last_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_first_r  <= 8'h00;
      min_second_r <= 8'h00;
      max_first_r  <= 8'hFF;
      max_second_r <= 8'hFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_FIRST:  min_first_r  <= cfg_data;
        REG_MIN_SECOND: min_second_r <= cfg_data;
        REG_MAX_FIRST:  max_first_r  <= cfg_data;
        REG_MAX_SECOND: max_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mrsg_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_seed   (in_tdata),
    .mem       (mem),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  mrsg_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TW_N)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r[7:0]  <= (res.first_raw | min_first_r) & max_first_r;
      out_data_r[15:8] <= (res.second_raw | min_second_r) & max_second_r;
      out_last_r       <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[sv/mrsg_ram.sv]
// Generic single-write, single-read synchronous RAM, registered read.
// No package dependency.
module mrsg_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 312
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/mrsg_ctrl.sv]
// Sequencer and datapath: seeding with a shared 32x32 multiplier, and lazy
// in-place twisting of one state word per draw. Uses mrsg_pkg and the macros.
`include "masked_random_stamp_generator_unit_defines.svh"
module mrsg_ctrl #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [63:0]           in_seed,
  output mrsg_pkg::mem_req_t    mem,
  input  logic [63:0]           mem_rdata,
  output logic                  res_valid,
  input  logic                  res_ready,
  output mrsg_pkg::res_t        res
);
  import mrsg_pkg::*;

  localparam int unsigned CNT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [ADDR_W-1:0] N_A      = ADDR_W'(TW_N);
  localparam logic [ADDR_W-1:0] M_A      = ADDR_W'(TW_M);
  localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(TW_N - 1);
  localparam logic [CNT_W-1:0]  LAST_CNT = CNT_W'(ENTRIES - 1);

  function automatic logic [63:0] temper(input logic [63:0] v);
    logic [63:0] z;
    z = v;
    z = z ^ ((z >> 29) & 64'h5555_5555_5555_5555);
    z = z ^ ((z << 17) & 64'h71D6_7FFF_EDA6_0000);
    z = z ^ ((z << 37) & 64'hFFF7_EEE0_0000_0000);
    z = z ^ (z >> 43);
    return z;
  endfunction

  function automatic logic [ADDR_W-1:0] step1(input logic [ADDR_W-1:0] i);
    return (i == LAST_A) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] stepm(input logic [ADDR_W-1:0] i);
    return (i < M_A) ? i + M_A : i - M_A;
  endfunction

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              sel_r, sel_nxt;
  logic [ADDR_W-1:0] cur_r, cur_nxt;
  logic [ADDR_W-1:0] seed_i_r, seed_i_nxt;
  logic [63:0]       p_r, p_nxt;
  logic [63:0]       pll_r, pll_nxt;
  logic [31:0]       cross_r, cross_nxt;
  logic [63:0]       a_r, a_nxt;
  logic [63:0]       b_r, b_nxt;
  logic [7:0]        byte0_r, byte0_nxt;
  logic [7:0]        byte1_r, byte1_nxt;
  logic              last_r, last_nxt;

  logic [63:0] x;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] y;
  logic [63:0] twisted;
  logic [63:0] tempered;
  logic [63:0] seed_word;

  assign x        = p_r ^ (p_r >> 62);
  assign prod     = 64'(mul_a) * 64'(mul_b);
  assign y        = (a_r & TW_UPPER) | (b_r & TW_LOWER);
  assign twisted  = mem_rdata ^ (y >> 1) ^ (y[0] ? TW_MATRIX : 64'h0);
  assign tempered = temper(twisted);
  assign seed_word = pll_r + {cross_r, 32'h0} + 64'(seed_i_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= N_A;
      cnt_r <= '0;
      sel_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      cnt_r <= cnt_nxt;
      sel_r <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    seed_i_r <= seed_i_nxt;
    p_r      <= p_nxt;
    pll_r    <= pll_nxt;
    cross_r  <= cross_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    byte0_r  <= byte0_nxt;
    byte1_r  <= byte1_nxt;
    last_r   <= last_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    sel_nxt    = sel_r;
    cur_nxt    = cur_r;
    seed_i_nxt = seed_i_r;
    p_nxt      = p_r;
    pll_nxt    = pll_r;
    cross_nxt  = cross_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    byte0_nxt  = byte0_r;
    byte1_nxt  = byte1_r;
    last_nxt   = last_r;
    mul_a      = x[31:0];
    mul_b      = INIT_MUL_LO;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    mem.we     = 1'b0;
    mem.waddr  = cur_r;
    mem.wdata  = twisted;
    mem.raddr  = cur_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_SEED) begin
            mem.we     = 1'b1;
            mem.waddr  = '0;
            mem.wdata  = in_seed;
            p_nxt      = in_seed;
            seed_i_nxt = ADDR_W'(1);
            idx_nxt    = N_A;
            cnt_nxt    = '0;
            state_nxt  = ST_SM0;
          end else begin
            // index at the end of the state means a fresh generation
            cur_nxt   = (idx_r >= N_A) ? '0 : idx_r;
            sel_nxt   = 1'b0;
            state_nxt = ST_RA;
          end
        end
      end
      ST_SM0: begin
        pll_nxt   = prod;
        state_nxt = ST_SM1;
      end
      ST_SM1: begin
        mul_a     = x[63:32];
        cross_nxt = prod[31:0];
        state_nxt = ST_SM2;
      end
      ST_SM2: begin
        mul_b     = INIT_MUL_HI;
        cross_nxt = cross_r + prod[31:0];
        state_nxt = ST_SM3;
      end
      ST_SM3: begin
        mem.we    = 1'b1;
        mem.waddr = seed_i_r;
        mem.wdata = seed_word;
        p_nxt     = seed_word;
        if (seed_i_r == LAST_A) begin
          state_nxt = ST_IDLE;
        end else begin
          seed_i_nxt = seed_i_r + 1'b1;
          state_nxt  = ST_SM0;
        end
      end
      ST_RA: begin
        mem.raddr = cur_r;
        state_nxt = ST_RB;
      end
      ST_RB: begin
        mem.raddr = step1(cur_r);
        a_nxt     = mem_rdata;
        state_nxt = ST_RC;
      end
      ST_RC: begin
        mem.raddr = stepm(cur_r);
        b_nxt     = mem_rdata;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        // words below cur are already of the new generation, so the
        // in-place update matches a full regeneration
        mem.we    = 1'b1;
        mem.waddr = cur_r;
        mem.wdata = twisted;
        cur_nxt   = step1(cur_r);
        if (!sel_r) begin
          byte0_nxt = tempered[7:0];
          sel_nxt   = 1'b1;
          state_nxt = ST_RA;
        end else begin
          byte1_nxt = tempered[7:0];
          idx_nxt   = step1(cur_r);
          last_nxt  = (cnt_r == LAST_CNT);
          cnt_nxt   = (cnt_r == LAST_CNT) ? '0 : cnt_r + 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res.first_raw  = byte0_r;
  assign res.second_raw = byte1_r;
  assign res.last       = last_r;

  `MRSG_ASSERT_IMPL(a_idx_range, 1'b1, idx_r <= N_A)
  `MRSG_ASSERT_IMPL(a_wr_addr, mem.we, mem.waddr < N_A)
  `MRSG_ASSERT_IMPL(a_busy_emit, res_valid, !in_ready)
  `MRSG_ASSERT_NEXT(a_emit_idle, res_valid && res_ready, in_ready)

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for masked_random_stamp_generator_unit.
// Needs mrsg_pkg and the unit's RTL; carries its own 64-bit twister model.
module tb;

  localparam int unsigned STAMP_ENTRIES = 256;
  localparam int unsigned WORD_TARGET   = 1900;
  localparam int unsigned SEED_CYCLES   = 1300;   // seed load plus margin
  localparam int unsigned STALL_LIMIT   = 20000;
  localparam int unsigned LONG_HOLD_AT  = 100;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned MAX_PRINTS    = 20;

  localparam int unsigned TWIST_N   = 312;
  localparam int unsigned TWIST_M   = 156;
  localparam logic [63:0] TWIST_XOR = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] TWIST_HI  = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] TWIST_LO  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] SEED_MUL  = 64'd6364136223846793005;

  typedef struct {
    logic [7:0] first;
    logic [7:0] second;
    logic       last;
  } stamp_entry_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [7:0]  reg_idx;
    logic [7:0]  reg_val;
    logic        op;
    logic [63:0] seed;
    logic        typed;
    logic [7:0]  typed_first;
    logic [7:0]  typed_second;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;    // [63:0] seed
  logic        in_tuser;    // [0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;   // [7:0] first_value, [15:8] second_value
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [7:0]  cfg_data;

  // twister and stamp model
  logic [63:0]  twist_words [TWIST_N];
  int unsigned  twist_pos;
  int unsigned  entry_pos;
  logic [7:0]   or_mask_first, or_mask_second, and_mask_first, and_mask_second;

  stamp_entry_t pending_entries [$];
  stamp_entry_t want;
  plan_row_t    plan [$];
  int unsigned  mismatch_count;
  int unsigned  words_sent;
  int unsigned  idle_cycles;
  int unsigned  feed_gap_max;
  int unsigned  drain_gap_max;

  masked_random_stamp_generator_unit #(.ENTRIES(STAMP_ENTRIES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void twist_seed(input logic [63:0] seed);
    int unsigned i;
    twist_words[0] = seed;
    for (i = 1; i < TWIST_N; i++)
      twist_words[i] = SEED_MUL * (twist_words[i-1] ^ (twist_words[i-1] >> 62)) + 64'(i);
    twist_pos = TWIST_N;
  endfunction

  function automatic logic [63:0] twist_draw();
    int unsigned i;
    logic [63:0] y, z;
    if (twist_pos >= TWIST_N) begin
      for (i = 0; i < TWIST_N; i++) begin
        y = (twist_words[i] & TWIST_HI) | (twist_words[(i + 1) % TWIST_N] & TWIST_LO);
        twist_words[i] = twist_words[(i + TWIST_M) % TWIST_N] ^ (y >> 1) ^
                         (y[0] ? TWIST_XOR : 64'd0);
      end
      twist_pos = 0;
    end
    z = twist_words[twist_pos];
    twist_pos++;
    z ^= (z >> 29) & 64'h5555_5555_5555_5555;
    z ^= (z << 17) & 64'h71D6_7FFF_EDA6_0000;
    z ^= (z << 37) & 64'hFFF7_EEE0_0000_0000;
    z ^= z >> 43;
    return z;
  endfunction

  function automatic stamp_entry_t next_stamp_entry();
    stamp_entry_t e;
    logic [63:0]  r;
    r = twist_draw();
    e.first = (r[7:0] | or_mask_first) & and_mask_first;
    r = twist_draw();
    e.second = (r[7:0] | or_mask_second) & and_mask_second;
    e.last = (entry_pos == STAMP_ENTRIES - 1);
    entry_pos = e.last ? 0 : entry_pos + 1;
    return e;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] wanted);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t: %s got %0h wanted %0h", $time, what, got, wanted);
    mismatch_count++;
  endtask

  // one input word; typed rows replace the model's entry but still advance it
  task automatic send_word(input logic op, input logic [63:0] seed, input logic typed = 1'b0,
                           input logic [7:0] t_first = 8'd0, input logic [7:0] t_second = 8'd0);
    int unsigned  gap;
    stamp_entry_t e;
    gap = $urandom_range(feed_gap_max, 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= seed;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (op == mrsg_pkg::OP_SEED) begin
      twist_seed(seed);
      entry_pos = 0;
    end else begin
      e = next_stamp_entry();
      if (typed) begin
        e.first  = t_first;
        e.second = t_second;
      end
      pending_entries.push_back(e);
    end
  endtask

  // cfg_valid is left high so back-to-back writes follow with no gap
  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mrsg_pkg::REG_MIN_FIRST:  or_mask_first   = val;
      mrsg_pkg::REG_MIN_SECOND: or_mask_second  = val;
      mrsg_pkg::REG_MAX_FIRST:  and_mask_first  = val;
      mrsg_pkg::REG_MAX_SECOND: and_mask_second = val;
      default: ;
    endcase
  endtask

  // a seed gives no entry, so allow for one still loading
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (SEED_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_seed();
    case ($urandom_range(7, 0))
      0:       return 64'd0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] pick_mask();
    case ($urandom_range(3, 0))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void add_word(input logic op, input logic [63:0] seed);
    plan.push_back('{ROW_WORD, 8'd0, 8'd0, op, seed, 1'b0, 8'd0, 8'd0});
  endfunction

  function automatic void add_typed(input logic [7:0] f, input logic [7:0] s);
    plan.push_back('{ROW_WORD, 8'd0, 8'd0, mrsg_pkg::OP_NEXT, '1, 1'b1, f, s});
  endfunction

  function automatic void add_cfg(input logic [7:0] idx, input logic [7:0] val);
    plan.push_back('{ROW_CFG, idx, val, mrsg_pkg::OP_NEXT, 64'd0, 1'b0, 8'd0, 8'd0});
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_entries.size() == 0) begin
        report_mismatch("unexpected word", {47'd0, out_tlast, out_tdata}, 64'd0);
      end else begin
        want = pending_entries.pop_front();
        if (out_tdata[7:0] !== want.first)
          report_mismatch("first_value", 64'(out_tdata[7:0]), 64'(want.first));
        if (out_tdata[15:8] !== want.second)
          report_mismatch("second_value", 64'(out_tdata[15:8]), 64'(want.second));
        if (out_tlast !== want.last)
          report_mismatch("last_entry", 64'(out_tlast), 64'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("masked_random_stamp_generator_unit: mismatch");
        $finish;
      end
    end
  end

  // receiver: random holds, bursts with none, one long hold to back the unit up
  initial begin
    int unsigned hold, taken;
    taken = 0;
    drain_gap_max = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 48 == 0) drain_gap_max = $urandom_range(1, 0) ? 11 : 0;
      hold = (taken == LONG_HOLD_AT) ? LONG_HOLD : $urandom_range(drain_gap_max, 0);
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  initial begin
    int unsigned phase, phase_words, run_len, r;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= mrsg_pkg::OP_SEED;
    in_tdata   <= 64'd0;
    cfg_valid  <= 1'b0;
    cfg_index  <= mrsg_pkg::REG_MIN_FIRST;
    cfg_data   <= 8'd0;
    idle_cycles    = 0;
    mismatch_count = 0;
    words_sent     = 0;
    feed_gap_max   = 11;
    twist_pos      = TWIST_N;
    entry_pos      = 0;
    or_mask_first   = 8'h00;
    or_mask_second  = 8'h00;
    and_mask_first  = 8'hFF;
    and_mask_second = 8'hFF;

    // directed: seed extremes, forced and cleared masks, out-of-range index,
    // reseed in the middle of a stamp
    add_word(mrsg_pkg::OP_SEED, 64'd0);
    add_word(mrsg_pkg::OP_NEXT, 64'd0);
    add_word(mrsg_pkg::OP_NEXT, '1);
    add_word(mrsg_pkg::OP_SEED, '1);
    add_word(mrsg_pkg::OP_NEXT, 64'd0);
    add_word(mrsg_pkg::OP_SEED, 64'd5489);
    add_word(mrsg_pkg::OP_NEXT, 64'h5555_5555_5555_5555);
    add_cfg(mrsg_pkg::REG_MIN_FIRST, 8'hFF);
    add_cfg(mrsg_pkg::REG_MIN_SECOND, 8'hFF);
    add_typed(8'hFF, 8'hFF);
    add_cfg(mrsg_pkg::REG_MAX_FIRST, 8'h00);
    add_cfg(mrsg_pkg::REG_MAX_SECOND, 8'h00);
    add_typed(8'h00, 8'h00);
    add_cfg(mrsg_pkg::REG_MIN_FIRST, 8'h0F);
    add_cfg(mrsg_pkg::REG_MIN_SECOND, 8'hF0);
    add_cfg(mrsg_pkg::REG_MAX_FIRST, 8'hFF);
    add_cfg(mrsg_pkg::REG_MAX_SECOND, 8'hFF);
    add_word(mrsg_pkg::OP_NEXT, 64'hAAAA_AAAA_AAAA_AAAA);
    add_cfg(8'd4, 8'h00);
    add_cfg(8'hFF, 8'h00);
    add_word(mrsg_pkg::OP_NEXT, 64'd0);
    add_word(mrsg_pkg::OP_SEED, 64'h8000_0000_0000_0001);
    add_word(mrsg_pkg::OP_NEXT, 64'd0);
    add_word(mrsg_pkg::OP_NEXT, 64'd0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (i == 0 || plan[i-1].kind != ROW_CFG) settle_block();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        if (i > 0 && plan[i-1].kind == ROW_CFG) cfg_valid <= 1'b0;
        send_word(plan[i].op, plan[i].seed, plan[i].typed,
                  plan[i].typed_first, plan[i].typed_second);
      end
    end

    // random phases, each under its own mask setting
    phase = 0;
    while (words_sent < WORD_TARGET) begin
      settle_block();
      if (phase == 0) begin
        write_reg(mrsg_pkg::REG_MIN_FIRST, 8'h00);
        write_reg(mrsg_pkg::REG_MIN_SECOND, 8'h00);
        write_reg(mrsg_pkg::REG_MAX_FIRST, 8'hFF);
        write_reg(mrsg_pkg::REG_MAX_SECOND, 8'hFF);
      end else begin
        write_reg(mrsg_pkg::REG_MIN_FIRST, pick_mask());
        write_reg(mrsg_pkg::REG_MIN_SECOND, pick_mask());
        write_reg(mrsg_pkg::REG_MAX_FIRST, pick_mask());
        write_reg(mrsg_pkg::REG_MAX_SECOND, pick_mask());
        if ($urandom_range(3, 0) == 0) write_reg(8'($urandom_range(255, 4)), 8'($urandom));
      end
      cfg_valid <= 1'b0;

      if (phase == 0) begin
        // full stamp and then some, fed flat out against the long receiver hold
        feed_gap_max = 0;
        send_word(mrsg_pkg::OP_SEED, pick_seed());
        repeat (300) send_word(mrsg_pkg::OP_NEXT, {$urandom, $urandom});
      end else begin
        feed_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 11;
        phase_words = 0;
        while (phase_words < 200 && words_sent < WORD_TARGET) begin
          if ($urandom_range(3, 0) != 0) send_word(mrsg_pkg::OP_SEED, pick_seed());
          r = $urandom_range(15, 0);
          run_len = (r == 0) ? $urandom_range(300, 250) : $urandom_range(40, 0);
          repeat (run_len) send_word(mrsg_pkg::OP_NEXT, {$urandom, $urandom});
          phase_words += run_len + 1;
          if ($urandom_range(7, 0) == 0) begin
            // hold the feed until every entry is back
            in_tvalid <= 1'b0;
            do @(posedge clk); while (pending_entries.size() != 0);
          end
        end
      end
      phase++;
    end

    in_tvalid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (SEED_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("masked_random_stamp_generator_unit: match");
    end else begin
      $display("masked_random_stamp_generator_unit: mismatch");
    end
    $finish;
  end

endmodule
